// ===== rtl/kdlp_pkg.sv =====
// kdlp_pkg: shared types, codes and sizing constants of the key debounce block
// no dependencies
package kdlp_pkg;

	localparam int NUM_KEYS    = 3;
	localparam int COUNT_WIDTH = 16;

	// payload widths fixed by the item format
	localparam int KEY_W    = 2;
	localparam int EVENT_W  = 3;
	localparam int LEARN_W  = 2;
	localparam int ACTION_W = 3;
	localparam int TICKS_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// operations
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// events
	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_HOLD1   = 3'd2;
	localparam logic [EVENT_W-1:0] EV_HOLD2   = 3'd3;
	localparam logic [EVENT_W-1:0] EV_HOLD3   = 3'd4;
	localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd5;

	// rf learn codes
	localparam logic [LEARN_W-1:0] LEARN_NONE  = 2'd0;
	localparam logic [LEARN_W-1:0] LEARN_START = 2'd1;
	localparam logic [LEARN_W-1:0] LEARN_STOP  = 2'd2;

	// dimmer actions
	localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_LIGHT_ON   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEARED    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ADJ_START  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_ADJ_COMMIT = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_LIGHT_OFF  = 3'd5;

	// dimmer modes
	localparam logic [1:0] DIM_OFF    = 2'd0;
	localparam logic [1:0] DIM_ONOFF  = 2'd1;
	localparam logic [1:0] DIM_ADJUST = 2'd2;
	localparam logic [1:0] DIM_ALIAS  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD1        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD2        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD3        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIMMER_MODE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_ENABLE = 3'd6;

	typedef struct packed {
		logic [2:0]         key_enable;
		logic [TICKS_W-1:0] debounce_ticks;
		logic [TICKS_W-1:0] hold1_ticks;
		logic [TICKS_W-1:0] hold2_ticks;
		logic [TICKS_W-1:0] hold3_ticks;
		logic [1:0]         dimmer_mode;
		logic               learn_enable;
	} cfg_t;

	typedef struct packed {
		logic                   debounced;
		logic [2:0]             hold_levels;
		logic [COUNT_WIDTH-1:0] debounce_count;
		logic [COUNT_WIDTH-1:0] hold1_count;
		logic [COUNT_WIDTH-1:0] hold2_count;
		logic [COUNT_WIDTH-1:0] hold3_count;
		logic                   light_status;
		logic                   press_seen;
		logic                   adjusting;
	} key_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key_id;
		logic [EVENT_W-1:0]  event_res;
		logic                beep;
		logic [LEARN_W-1:0]  learn;
		logic [ACTION_W-1:0] action;
		logic                switch_status;
	} result_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] cnt;
		logic                   fire;
	} count_step_t;

	// one counted tick: wrap, compare against the limit, clear on hit
	function automatic count_step_t count_step(input logic [COUNT_WIDTH-1:0] cnt,
		input logic [TICKS_W-1:0] limit);
		count_step_t r;
		logic [COUNT_WIDTH-1:0] inc;
		inc = cnt + COUNT_WIDTH'(1);
		r.fire = (33'(inc) >= 33'(limit));
		r.cnt  = r.fire ? '0 : inc;
		return r;
	endfunction

endpackage

// ===== rtl/kdlp_if.sv =====
// kdlp_if: handshake channels of the key debounce block (items, results, config writes)
// depends on kdlp_pkg
interface kdlp_item_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [kdlp_pkg::KEY_W-1:0]  key_index;
	logic                        key_touch;
	logic                        status_value;
	modport source (output valid, operation, key_index, key_touch, status_value, input ready);
	modport sink (input valid, operation, key_index, key_touch, status_value, output ready);
endinterface

interface kdlp_result_if;
	logic                          valid;
	logic                          ready;
	logic [kdlp_pkg::KEY_W-1:0]    key_id;
	logic [kdlp_pkg::EVENT_W-1:0]  event_res;
	logic                          beep;
	logic [kdlp_pkg::LEARN_W-1:0]  learn;
	logic [kdlp_pkg::ACTION_W-1:0] action;
	logic                          switch_status;
	modport source (output valid, key_id, event_res, beep, learn, action, switch_status,
		input ready);
	modport sink (input valid, key_id, event_res, beep, learn, action, switch_status,
		output ready);
endinterface

interface kdlp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [kdlp_pkg::CFG_IDX_W-1:0]    index;
	logic [kdlp_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/key_debounce_long_press_unit.sv =====
// key_debounce_long_press_unit: a transaction lands in the input stage at its accepting
// edge and moves on into the result register when that register is free or being taken;
// one transaction per cycle sustained while the result sink holds ready, since each key's
// state is a read-modify-write in between
// asynchronous active-low reset clears all key state, empties both stages and loads
// the register defaults; depends on kdlp_pkg, kdlp_if, kdlp_cfg and kdlp_core
module key_debounce_long_press_unit (
	input  logic          clk,
	input  logic          arst_n,
	kdlp_cfg_if.sink      cfg,
	kdlp_item_if.sink     item,
	kdlp_result_if.source result
);

	// live configuration; the user must write it only while no transaction is in flight, the block does not enforce this
	kdlp_pkg::cfg_t regs;

	// register file for key enable, thresholds, dimmer mode and learn enable
	kdlp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// debounce, hold levels and dimmer actions per key; the result register
	// decouples the sinks so a new item is taken while a result waits, as long
	// as the input stage is empty
	kdlp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.item   (item),
		.result (result)
	);

endmodule

// ===== rtl/kdlp_cfg.sv =====
// kdlp_cfg: configuration register file of the key debounce block
// depends on kdlp_pkg and kdlp_cfg_if
module kdlp_cfg (
	input  logic              clk,
	input  logic              arst_n,
	kdlp_cfg_if.sink          cfg,
	output kdlp_pkg::cfg_t    regs
);

	kdlp_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.key_enable     <= 3'd0;
			regs_q.debounce_ticks <= 16'd20;
			regs_q.hold1_ticks    <= 16'd1000;
			regs_q.hold2_ticks    <= 16'd3000;
			regs_q.hold3_ticks    <= 16'd10000;
			regs_q.dimmer_mode    <= kdlp_pkg::DIM_ADJUST;
			regs_q.learn_enable   <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				kdlp_pkg::REG_KEY_ENABLE:   regs_q.key_enable     <= cfg.data[2:0];
				kdlp_pkg::REG_DEBOUNCE:     regs_q.debounce_ticks <= cfg.data;
				kdlp_pkg::REG_HOLD1:        regs_q.hold1_ticks    <= cfg.data;
				kdlp_pkg::REG_HOLD2:        regs_q.hold2_ticks    <= cfg.data;
				kdlp_pkg::REG_HOLD3:        regs_q.hold3_ticks    <= cfg.data;
				kdlp_pkg::REG_DIMMER_MODE:  regs_q.dimmer_mode    <= cfg.data[1:0];
				kdlp_pkg::REG_LEARN_ENABLE: regs_q.learn_enable   <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/kdlp_core.sv =====
// kdlp_core: input stage, per-key state, next-state logic and result register
// depends on kdlp_pkg, kdlp_item_if and kdlp_result_if
module kdlp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  kdlp_pkg::cfg_t    regs,
	kdlp_item_if.sink         item,
	kdlp_result_if.source     result
);

	// input stage
	logic                       valid_s1;
	logic                       op_s1;
	logic [kdlp_pkg::KEY_W-1:0] key_s1;
	logic                       touch_s1;
	logic                       sval_s1;

	// result stage
	logic                       res_valid_q;
	kdlp_pkg::result_t          res_q;

	kdlp_pkg::key_state_t       st_q [kdlp_pkg::NUM_KEYS];

	logic                       advance;
	kdlp_pkg::key_state_t       cur;
	kdlp_pkg::key_state_t       nxt;
	kdlp_pkg::result_t          res_d;

	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1    <= item.operation;
			key_s1   <= item.key_index;
			touch_s1 <= item.key_touch;
			sval_s1  <= item.status_value;
		end
	end

	// next state and result of the item held in the input stage
	always_comb begin
		logic                           in_range;
		logic [2:0]                     en_sh;
		logic [1:0]                     mode;
		kdlp_pkg::count_step_t          cs;

		in_range = (int'(key_s1) < kdlp_pkg::NUM_KEYS);
		en_sh    = regs.key_enable >> key_s1;
		mode     = (regs.dimmer_mode == kdlp_pkg::DIM_ALIAS) ? kdlp_pkg::DIM_OFF
			: regs.dimmer_mode;

		cur = '0;
		for (int i = 0; i < kdlp_pkg::NUM_KEYS; i++) begin
			if (int'(key_s1) == i) begin
				cur = st_q[i];
			end
		end

		nxt   = cur;
		cs    = '0;
		res_d = '0;
		res_d.key_id = key_s1;

		if (in_range) begin
			if (op_s1 == kdlp_pkg::OP_WRITE) begin
				nxt.light_status = sval_s1;
			end else if (en_sh[0]) begin
				if (touch_s1) begin
					priority if (!cur.debounced) begin
						cs = kdlp_pkg::count_step(cur.debounce_count, regs.debounce_ticks);
						nxt.debounce_count = cs.cnt;
						if (cs.fire) begin
							nxt.debounced   = 1'b1;
							res_d.event_res = kdlp_pkg::EV_PRESS;
							res_d.beep      = 1'b1;
							if (mode != kdlp_pkg::DIM_OFF) begin
								nxt.press_seen   = 1'b1;
								nxt.light_status = !cur.light_status;
								res_d.action     = cur.light_status ? kdlp_pkg::ACT_CLEARED
									: kdlp_pkg::ACT_LIGHT_ON;
							end
						end
					end else if (!cur.hold_levels[0]) begin
						cs = kdlp_pkg::count_step(cur.hold1_count, regs.hold1_ticks);
						nxt.hold1_count = cs.cnt;
						if (cs.fire) begin
							nxt.hold_levels[0] = 1'b1;
							res_d.event_res    = kdlp_pkg::EV_HOLD1;
							if (mode == kdlp_pkg::DIM_ADJUST && cur.press_seen) begin
								nxt.adjusting    = 1'b1;
								nxt.light_status = 1'b1;
								res_d.action     = kdlp_pkg::ACT_ADJ_START;
							end
						end
					end else if (!cur.hold_levels[1]) begin
						cs = kdlp_pkg::count_step(cur.hold2_count, regs.hold2_ticks);
						nxt.hold2_count = cs.cnt;
						if (cs.fire) begin
							nxt.hold_levels[1] = 1'b1;
							res_d.event_res    = kdlp_pkg::EV_HOLD2;
							if (regs.learn_enable) begin
								res_d.learn = kdlp_pkg::LEARN_START;
							end
						end
					end else if (!cur.hold_levels[2]) begin
						cs = kdlp_pkg::count_step(cur.hold3_count, regs.hold3_ticks);
						nxt.hold3_count = cs.cnt;
						if (cs.fire) begin
							nxt.hold_levels[2] = 1'b1;
							res_d.event_res    = kdlp_pkg::EV_HOLD3;
							if (regs.learn_enable) begin
								res_d.learn = kdlp_pkg::LEARN_STOP;
							end
						end
					end else begin
					end
				end else if (cur.debounced) begin
					cs = kdlp_pkg::count_step(cur.debounce_count, regs.debounce_ticks);
					nxt.debounce_count = cs.cnt;
					if (cs.fire) begin
						nxt.debounced   = 1'b0;
						nxt.hold_levels = '0;
						nxt.hold1_count = '0;
						nxt.hold2_count = '0;
						nxt.hold3_count = '0;
						res_d.event_res = kdlp_pkg::EV_RELEASE;
						res_d.learn     = kdlp_pkg::LEARN_STOP;
						if (mode != kdlp_pkg::DIM_OFF && cur.press_seen) begin
							nxt.press_seen = 1'b0;
							if (cur.light_status) begin
								if (cur.adjusting) begin
									nxt.adjusting = 1'b0;
									res_d.action  = kdlp_pkg::ACT_ADJ_COMMIT;
								end
							end else begin
								res_d.action = kdlp_pkg::ACT_LIGHT_OFF;
							end
						end
					end
				end
			end
			res_d.switch_status = nxt.light_status;
		end
	end

	// state is written back at the edge that moves the item into the result register,
	// so a following item for the same key sees it without forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kdlp_pkg::NUM_KEYS; i++) begin
				st_q[i] <= '0;
			end
		end else if (valid_s1 && advance) begin
			for (int i = 0; i < kdlp_pkg::NUM_KEYS; i++) begin
				if (int'(key_s1) == i) begin
					st_q[i] <= nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.key_id        = res_q.key_id;
	assign result.event_res     = res_q.event_res;
	assign result.beep          = res_q.beep;
	assign result.learn         = res_q.learn;
	assign result.action        = res_q.action;
	assign result.switch_status = res_q.switch_status;

	a_beep_only_on_press: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.beep == (res_q.event_res == kdlp_pkg::EV_PRESS)))
		else $error("beep without press or press without beep");

	a_adj_start_at_hold1: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.action == kdlp_pkg::ACT_ADJ_START)
		|-> (res_q.event_res == kdlp_pkg::EV_HOLD1 && res_q.switch_status))
		else $error("adjust start outside hold level one");

	a_release_stops_learn: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.event_res == kdlp_pkg::EV_RELEASE)
		|-> (res_q.learn == kdlp_pkg::LEARN_STOP))
		else $error("release without learn stop");

	a_hold_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q[0].debounced |-> (st_q[0].hold_levels == 3'd0))
		else $error("hold level set on a released key");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(res_valid_q)) |-> $past(valid_s1))
		else $error("result without an item in the input stage");

endmodule

// ===== dv/key_debounce_long_press_unit_tb.sv =====
`timescale 1ns / 100ps
// key_debounce_long_press_unit_tb: self-checking testbench of the key debounce unit
// a predictor tracks each key's debounce, hold and dimmer state and checks every report
// depends on kdlp_pkg, kdlp_if and key_debounce_long_press_unit
module key_debounce_long_press_unit_tb;

	localparam int RUN_LIMIT = 200000;

	// one sample or status write as seen on the item channel
	typedef struct packed {
		logic                       op;
		logic [kdlp_pkg::KEY_W-1:0] key;
		logic                       touch;
		logic                       status_val;
	} key_item_t;

	logic clk;
	logic arst_n;

	kdlp_cfg_if    cfg_ch();
	kdlp_item_if   item_ch();
	kdlp_result_if result_ch();

	key_debounce_long_press_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	// predictor copy of the registers and of every key's state
	kdlp_pkg::cfg_t       qual_cfg;
	kdlp_pkg::key_state_t key_track [kdlp_pkg::NUM_KEYS];

	key_item_t          pending_samples [$];
	kdlp_pkg::result_t  expected_reports [$];
	key_item_t          on_bus;

	int unsigned queued_count;
	int unsigned checked_count;
	int unsigned effective_items;
	int unsigned mismatches;
	int unsigned cycle_count;

	// idle percentages of sender and receiver for the current phase
	int unsigned gap_pct;
	int unsigned stall_pct;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one counted tick: wraps at the counter width, clears and fires on reaching the limit
	function automatic logic [kdlp_pkg::COUNT_WIDTH:0] count_tick(
		input logic [kdlp_pkg::COUNT_WIDTH-1:0] cnt,
		input logic [kdlp_pkg::TICKS_W-1:0] lim);
		logic [kdlp_pkg::COUNT_WIDTH-1:0] nxt;
		nxt = cnt + kdlp_pkg::COUNT_WIDTH'(1);
		if (nxt >= lim)
			return {1'b1, {kdlp_pkg::COUNT_WIDTH{1'b0}}};
		return {1'b0, nxt};
	endfunction

	// advance one key by one item and form the report it produces
	function automatic kdlp_pkg::result_t predict_report(input key_item_t it);
		kdlp_pkg::result_t    r;
		kdlp_pkg::key_state_t s;
		logic [1:0]           mode;
		logic                 fire;
		r = '0;
		r.key_id = it.key;
		if (it.key < kdlp_pkg::NUM_KEYS) begin
			s = key_track[it.key];
			// the unused mode code behaves as no dimmer
			mode = (qual_cfg.dimmer_mode == kdlp_pkg::DIM_ALIAS) ? kdlp_pkg::DIM_OFF
				: qual_cfg.dimmer_mode;
			if (it.op == kdlp_pkg::OP_WRITE) begin
				// status writes land even on a disabled key
				s.light_status = it.status_val;
			end else if (qual_cfg.key_enable[it.key]) begin
				if (it.touch) begin
					if (!s.debounced) begin
						{fire, s.debounce_count} = count_tick(s.debounce_count,
							qual_cfg.debounce_ticks);
						if (fire) begin
							s.debounced = 1'b1;
							r.event_res = kdlp_pkg::EV_PRESS;
							r.beep = 1'b1;
							if (mode != kdlp_pkg::DIM_OFF) begin
								s.press_seen = 1'b1;
								r.action = s.light_status ? kdlp_pkg::ACT_CLEARED
									: kdlp_pkg::ACT_LIGHT_ON;
								s.light_status = !s.light_status;
							end
						end
					end else if (!s.hold_levels[0]) begin
						{fire, s.hold1_count} = count_tick(s.hold1_count,
							qual_cfg.hold1_ticks);
						if (fire) begin
							s.hold_levels[0] = 1'b1;
							r.event_res = kdlp_pkg::EV_HOLD1;
							if (mode == kdlp_pkg::DIM_ADJUST && s.press_seen) begin
								s.adjusting = 1'b1;
								s.light_status = 1'b1;
								r.action = kdlp_pkg::ACT_ADJ_START;
							end
						end
					end else if (!s.hold_levels[1]) begin
						{fire, s.hold2_count} = count_tick(s.hold2_count,
							qual_cfg.hold2_ticks);
						if (fire) begin
							s.hold_levels[1] = 1'b1;
							r.event_res = kdlp_pkg::EV_HOLD2;
							r.learn = qual_cfg.learn_enable ? kdlp_pkg::LEARN_START
								: kdlp_pkg::LEARN_NONE;
						end
					end else if (!s.hold_levels[2]) begin
						{fire, s.hold3_count} = count_tick(s.hold3_count,
							qual_cfg.hold3_ticks);
						if (fire) begin
							s.hold_levels[2] = 1'b1;
							r.event_res = kdlp_pkg::EV_HOLD3;
							r.learn = qual_cfg.learn_enable ? kdlp_pkg::LEARN_STOP
								: kdlp_pkg::LEARN_NONE;
						end
					end
					// past hold three a held key just sits
				end else if (s.debounced) begin
					{fire, s.debounce_count} = count_tick(s.debounce_count,
						qual_cfg.debounce_ticks);
					if (fire) begin
						s.debounced = 1'b0;
						s.hold_levels = '0;
						s.hold1_count = '0;
						s.hold2_count = '0;
						s.hold3_count = '0;
						r.event_res = kdlp_pkg::EV_RELEASE;
						// release stops learning regardless of learn_enable
						r.learn = kdlp_pkg::LEARN_STOP;
						if (mode != kdlp_pkg::DIM_OFF && s.press_seen) begin
							s.press_seen = 1'b0;
							if (s.light_status) begin
								if (s.adjusting) begin
									s.adjusting = 1'b0;
									r.action = kdlp_pkg::ACT_ADJ_COMMIT;
								end
							end else begin
								r.action = kdlp_pkg::ACT_LIGHT_OFF;
							end
						end
					end
				end
			end
			key_track[it.key] = s;
			r.switch_status = s.light_status;
		end
		return r;
	endfunction

	function automatic kdlp_pkg::cfg_t settings(input logic [2:0] en,
		input logic [kdlp_pkg::TICKS_W-1:0] deb,
		input logic [kdlp_pkg::TICKS_W-1:0] h1, input logic [kdlp_pkg::TICKS_W-1:0] h2,
		input logic [kdlp_pkg::TICKS_W-1:0] h3, input logic [1:0] dim, input logic lrn);
		kdlp_pkg::cfg_t c;
		c.key_enable     = en;
		c.debounce_ticks = deb;
		c.hold1_ticks    = h1;
		c.hold2_ticks    = h2;
		c.hold3_ticks    = h3;
		c.dimmer_mode    = dim;
		c.learn_enable   = lrn;
		return c;
	endfunction

	// valid stays high across back-to-back writes, the caller drops it once at the end
	task automatic write_reg(input logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
		input logic [kdlp_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
	endtask

	// must start right after a rising edge with the unit drained
	task automatic load_settings(input kdlp_pkg::cfg_t c);
		write_reg(kdlp_pkg::REG_KEY_ENABLE, kdlp_pkg::CFG_DATA_W'(c.key_enable));
		write_reg(kdlp_pkg::REG_DEBOUNCE, c.debounce_ticks);
		write_reg(kdlp_pkg::REG_HOLD1, c.hold1_ticks);
		write_reg(kdlp_pkg::REG_HOLD2, c.hold2_ticks);
		write_reg(kdlp_pkg::REG_HOLD3, c.hold3_ticks);
		write_reg(kdlp_pkg::REG_DIMMER_MODE, kdlp_pkg::CFG_DATA_W'(c.dimmer_mode));
		write_reg(kdlp_pkg::REG_LEARN_ENABLE, kdlp_pkg::CFG_DATA_W'(c.learn_enable));
		cfg_ch.valid <= 1'b0;
		qual_cfg = c;
	endtask

	task automatic add_item(input logic op, input logic [kdlp_pkg::KEY_W-1:0] key,
		input logic touch, input logic status_val);
		key_item_t it;
		it.op = op;
		it.key = key;
		it.touch = touch;
		it.status_val = status_val;
		pending_samples.push_back(it);
		queued_count++;
		// ignored items do not count toward the stimulus size
		if (key < kdlp_pkg::NUM_KEYS && (op == kdlp_pkg::OP_WRITE || qual_cfg.key_enable[key]))
			effective_items++;
	endtask

	// one key held for a while then let go, with bounces, status writes and stray items
	task automatic add_press_episode();
		int unsigned k;
		int unsigned span;
		int unsigned held;
		int unsigned released;
		int unsigned rel_max;
		do
			k = $urandom_range(0, kdlp_pkg::NUM_KEYS - 1);
		while (!qual_cfg.key_enable[k]);
		span = qual_cfg.debounce_ticks + qual_cfg.hold1_ticks + qual_cfg.hold2_ticks
			+ qual_cfg.hold3_ticks + 4;
		if (span > 40)
			span = 40;
		held = $urandom_range(1, span);
		rel_max = (qual_cfg.debounce_ticks > 8) ? 10 : qual_cfg.debounce_ticks + 2;
		released = $urandom_range(1, rel_max);
		for (int i = 0; i < held + released; i++) begin
			if ($urandom_range(0, 99) < 8)
				add_item(1'($urandom_range(0, 1)), kdlp_pkg::KEY_W'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else if ($urandom_range(0, 99) < 4)
				add_item(kdlp_pkg::OP_WRITE, kdlp_pkg::KEY_W'(k), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else
				add_item(kdlp_pkg::OP_TICK, kdlp_pkg::KEY_W'(k),
					(i < held) ^ ($urandom_range(0, 99) < 6), 1'($urandom_range(0, 1)));
		end
	endtask

	// every item gives exactly one report, so drained means all reports checked
	task automatic wait_drained();
		while (checked_count != queued_count)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// item driver: predict on acceptance, then present the next pending item or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				expected_reports.push_back(predict_report(on_bus));
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					on_bus = pending_samples.pop_front();
					item_ch.valid        <= 1'b1;
					item_ch.operation    <= on_bus.op;
					item_ch.key_index    <= on_bus.key;
					item_ch.key_touch    <= on_bus.touch;
					item_ch.status_value <= on_bus.status_val;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// report monitor: compare each accepted transaction with the oldest prediction
	always @(posedge clk) begin
		kdlp_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			checked_count++;
			if (expected_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected report, expected none, actual key %0d event %0d",
					$time, result_ch.key_id, result_ch.event_res);
			end else begin
				want = expected_reports.pop_front();
				check_field("key_id", want.key_id, result_ch.key_id);
				check_field("event_res", want.event_res, result_ch.event_res);
				check_field("beep", want.beep, result_ch.beep);
				check_field("learn", want.learn, result_ch.learn);
				check_field("action", want.action, result_ch.action);
				check_field("switch_status", want.switch_status, result_ch.switch_status);
			end
		end
		result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** key_debounce_long_press_unit: FAILED **");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = kdlp_pkg::OP_TICK;
		item_ch.key_index = '0;
		item_ch.key_touch = 1'b0;
		item_ch.status_value = 1'b0;
		result_ch.ready = 1'b0;
		queued_count = 0;
		checked_count = 0;
		effective_items = 0;
		mismatches = 0;
		// first phase: sender idles lightly, receiver stalls half the time
		gap_pct = 24;
		stall_pct = 50;

		// predictor starts from the reset defaults
		qual_cfg = settings(3'b000, 16'd20, 16'd1000, 16'd3000, 16'd10000,
			kdlp_pkg::DIM_ADJUST, 1'b1);
		for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++)
			key_track[k] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// defaults after reset: all keys disabled
		add_item(kdlp_pkg::OP_TICK, 2'd0, 1'b1, 1'b0);     // tick on a disabled key
		add_item(kdlp_pkg::OP_WRITE, 2'd1, 1'b0, 1'b1);    // status write on a disabled key
		add_item(kdlp_pkg::OP_TICK, 2'd3, 1'b1, 1'b1);     // key past the last one
		add_item(kdlp_pkg::OP_WRITE, 2'd3, 1'b1, 1'b1);
		wait_drained();

		// zero thresholds fire on the very next counted tick
		load_settings(settings(3'b111, 16'd0, 16'd1, 16'd1, 16'd0, kdlp_pkg::DIM_ADJUST,
			1'b1));
		// press, hold levels, then nothing
		repeat (5) add_item(kdlp_pkg::OP_TICK, 2'd0, 1'b1, 1'b0);
		add_item(kdlp_pkg::OP_TICK, 2'd0, 1'b0, 1'b0);     // release commits the adjust
		add_item(kdlp_pkg::OP_TICK, 2'd1, 1'b1, 1'b1);     // press with the light on clears it
		add_item(kdlp_pkg::OP_TICK, 2'd1, 1'b0, 1'b1);     // release then turns the light off
		wait_drained();

		// mode three aliases no dimmer, learn disabled but release still stops learning
		load_settings(settings(3'b010, 16'd1, 16'hffff, 16'hffff, 16'hffff,
			kdlp_pkg::DIM_ALIAS, 1'b0));
		add_item(kdlp_pkg::OP_TICK, 2'd1, 1'b1, 1'b0);
		add_item(kdlp_pkg::OP_TICK, 2'd1, 1'b1, 1'b1);
		add_item(kdlp_pkg::OP_TICK, 2'd1, 1'b0, 1'b0);
		add_item(kdlp_pkg::OP_TICK, 2'd0, 1'b1, 1'b0);
		wait_drained();

		// widest thresholds: counting only
		load_settings(settings(3'b101, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			kdlp_pkg::DIM_ONOFF, 1'b1));
		add_item(kdlp_pkg::OP_TICK, 2'd2, 1'b1, 1'b0);
		add_item(kdlp_pkg::OP_TICK, 2'd2, 1'b1, 1'b0);
		add_item(kdlp_pkg::OP_TICK, 2'd0, 1'b0, 1'b1);
		add_item(kdlp_pkg::OP_TICK, 2'd1, 1'b1, 1'b0);
		add_item(kdlp_pkg::OP_WRITE, 2'd2, 1'b0, 1'b0);
		wait_drained();

		// random phases with short thresholds so that every hold level is reached
		for (int seg = 0; seg < 6; seg++) begin
			unique case (seg / 2)
				0: begin
					gap_pct = 24;
					stall_pct = 50;
				end
				1: begin
					gap_pct = 50;
					stall_pct = 24;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			load_settings(settings(
				($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b111,
				kdlp_pkg::TICKS_W'($urandom_range(0, 4)),
				kdlp_pkg::TICKS_W'($urandom_range(0, 6)),
				kdlp_pkg::TICKS_W'($urandom_range(0, 6)),
				kdlp_pkg::TICKS_W'($urandom_range(0, 6)),
				2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
			effective_items = 0;
			while (effective_items < 100)
				add_press_episode();
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("** key_debounce_long_press_unit: PASSED **");
		else
			$display("** key_debounce_long_press_unit: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/kdlp_pkg.sv
rtl/kdlp_if.sv
rtl/kdlp_cfg.sv
rtl/kdlp_core.sv
rtl/key_debounce_long_press_unit.sv
dv/key_debounce_long_press_unit_tb.sv
